@@ rtl/core/two_stack_sort_core_defines.svh @@
// Assertion macros used by the two-stack sort checker.
`ifndef TWO_STACK_SORT_CORE_DEFINES_SVH
`define TWO_STACK_SORT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tss_pkg.sv @@
// Package with types and constants of the two-stack sort core.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int VALUE_W   = 32;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_HELD,
    ST_CMP,
    ST_TOP,
    ST_OUT_RD,
    ST_OUT_LD
  } tss_state_t;

endpackage

@@ rtl/core/two_stack_sort_core.sv @@
// Top level of the two-stack sort core: loader, sort sequencer and result stage.
//
//   Channel  Ports                         Contents
//   -------  ----------------------------  ------------------------------------------
//   input    in_tvalid/in_tready/in_tdata  value to load; in_tlast starts the sort
//   output   out_tvalid/out_tready/...     values in descending order; tlast on the
//                                          final one, tuser flags dropped inputs
//
// Loading takes one transfer per cycle while in_tready is high. After the last input
// the sequencer runs the two-stack sort through a single signed comparator: each
// compare step is a stack move followed, unless the sorted stack ran empty, by the
// registered RAM read that refills the held or top element. Each result is then read
// only once the output register has drained, so the next read waits for the previous
// result to be taken. Reset is synchronous and clears only control state; the stack
// RAMs are not cleared since entries above the counts are never read. in_tready is
// low from the last input until the final result sits in the output register; that
// result may wait while the next set loads.
`timescale 1ns / 1ps

module two_stack_sort_core #(
  parameter int DEPTH = tss_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tss_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic                        in_tlast,   // last
  // Result channel.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tss_pkg::VALUE_W-1:0] out_tdata,  // [31:0] value_res
  output logic                        out_tlast,  // last_res
  output logic                        out_tuser   // [0] overflowed
);

  import tss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  tss_state_t state_r, state_nxt;

  // Stack depths, held element and cached top of the sorted stack.
  logic [CW-1:0]      src_cnt_r, src_cnt_nxt;
  logic [CW-1:0]      srt_cnt_r, srt_cnt_nxt;
  logic [VALUE_W-1:0] held_r, held_nxt;
  logic [VALUE_W-1:0] top_r, top_nxt;
  logic               ovf_r, ovf_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_user_r, out_user_nxt;

  // Stack RAM ports.
  logic               src_we, srt_we;
  logic [AW-1:0]      src_waddr, src_raddr, srt_waddr, srt_raddr;
  logic [VALUE_W-1:0] src_wdata, src_rdata, srt_wdata, srt_rdata;

  logic in_xfer;
  logic top_gt;
  logic loop_go;

  tss_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  tss_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_srt_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  assign in_tready  = (state_r == ST_LOAD);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // The one shared comparator: is the sorted stack's top strictly above the held value?
  assign top_gt  = $signed(top_r) > $signed(held_r);
  // The sort keeps going while source values remain or the held value still has to
  // sink below larger entries of the sorted stack.
  assign loop_go = (src_cnt_r != '0) || ((srt_cnt_r != '0) && top_gt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      src_cnt_r   <= '0;
      srt_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_cnt_r   <= src_cnt_nxt;
      srt_cnt_r   <= srt_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    src_cnt_nxt   = src_cnt_r;
    srt_cnt_nxt   = srt_cnt_r;
    held_nxt      = held_r;
    top_nxt       = top_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    src_we    = 1'b0;
    src_waddr = src_cnt_r[AW-1:0];
    src_wdata = in_tdata;
    src_raddr = AW'(src_cnt_r - ONE_C);
    srt_we    = 1'b0;
    srt_waddr = srt_cnt_r[AW-1:0];
    srt_wdata = held_r;
    srt_raddr = AW'(srt_cnt_r - ONE_C);

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (src_cnt_r < DEPTH_C) begin
            src_we      = 1'b1;
            src_cnt_nxt = src_cnt_r + ONE_C;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            srt_cnt_nxt = '0;
            state_nxt   = ST_START;
          end
        end
      end

      ST_START: begin
        // Pop the first held value off the source stack, or go back to loading if it is empty.
        if (src_cnt_r == '0) begin
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          src_cnt_nxt = src_cnt_r - ONE_C;
          state_nxt   = ST_HELD;
        end
      end

      ST_HELD: begin
        held_nxt  = src_rdata;
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        if (!loop_go) begin
          // Sort done: the held value goes on top of the sorted stack.
          srt_we      = 1'b1;
          srt_cnt_nxt = srt_cnt_r + ONE_C;
          state_nxt   = ST_OUT_RD;
        end else if ((srt_cnt_r == '0) || !top_gt) begin
          // Held value fits on the sorted stack; fetch the next source value.
          srt_we      = 1'b1;
          srt_cnt_nxt = srt_cnt_r + ONE_C;
          top_nxt     = held_r;
          src_cnt_nxt = src_cnt_r - ONE_C;
          state_nxt   = ST_HELD;
        end else begin
          // Larger sorted value moves back to the source stack.
          src_we      = 1'b1;
          src_wdata   = top_r;
          src_cnt_nxt = src_cnt_r + ONE_C;
          srt_cnt_nxt = srt_cnt_r - ONE_C;
          srt_raddr   = AW'(srt_cnt_r - TWO_C);
          state_nxt   = (srt_cnt_r > ONE_C) ? ST_TOP : ST_CMP;
        end
      end

      ST_TOP: begin
        top_nxt   = srt_rdata;
        state_nxt = ST_CMP;
      end

      ST_OUT_RD: begin
        // Read the next result once the output register is free.
        if (!out_valid_r) begin
          srt_cnt_nxt = srt_cnt_r - ONE_C;
          state_nxt   = ST_OUT_LD;
        end
      end

      ST_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = srt_rdata;
        out_last_nxt  = (srt_cnt_r == '0);
        out_user_nxt  = ovf_r;
        if (srt_cnt_r == '0) begin
          src_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = ST_LOAD;
        end else begin
          state_nxt = ST_OUT_RD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/core/tss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tss_checker.sv @@
// Port-level checker for the two-stack sort core, bound to the top level.
`timescale 1ns / 1ps
`include "two_stack_sort_core_defines.svh"

module tss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [tss_pkg::VALUE_W-1:0] out_tdata,
  input logic                        out_tlast,
  input logic                        out_tuser
);

  // A stalled result keeps its payload.
  `TSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser),
    "result changed while stalled")

  // The last input starts the sort, so loading stops right after it.
  `TSS_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready,
    "input accepted right after the last transfer")

  // A new result is only produced after loading has stopped.
  `TSS_ASSERT_NOW(a_result_origin, $rose(out_tvalid), !$past(in_tready),
    "result appeared while inputs were being loaded")

  // The overflow flag is the same on every result of a run.
  `TSS_ASSERT_NEXT(a_flag_steady, out_tvalid && out_tready && !out_tlast,
    out_tuser == $past(out_tuser), "overflow flag changed within a run")

endmodule

bind two_stack_sort_core tss_checker u_tss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the two-stack sort core, with directed and random sets.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = tss_pkg::DEPTH_DEF;

  // The run is ended here if the results stop coming.
  localparam int CYCLE_LIMIT = 300000;

  // How long the receiver refuses results once, to back the core up into its input.
  localparam int HOLD_CYCLES = 600;

  // Number of random transfers at the end that run with no idling on either side.
  localparam int CALM_TAIL = 30;

  // One result of a sorted run, as the output channel carries it.
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  // One line of the directed table. Where typed is set, the row closes a set of a
  // single value, so its one result is known without running the sort.
  typedef struct {
    logic [31:0] value;
    bit          last;
    bit          typed;
    logic [31:0] exp_value;
  } load_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  // Our own copy of the two stacks and the counts, updated on every accepted transfer.
  logic signed [31:0] src_stk [DEPTH];
  logic signed [31:0] srt_stk [DEPTH];
  int                 src_n = 0;
  int                 srt_n = 0;
  bit                 ovf_seen = 1'b0;

  // Results that the core still owes, oldest first.
  sorted_word_t pending_words[$];
  load_row_t    load_rows[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;      // Set for the tail of the run: no idling anywhere.
  bit  hold_req = 1'b0;  // Asks the receiver for its one long hold-off.

  two_stack_sort_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Predictor. Each accepted value is pushed onto the source stack, or dropped and
  // flagged when the stack is full. A last transfer runs the two-stack sort: the held
  // element goes onto the sorted stack only when it is not below the top there,
  // otherwise the top moves back to the source stack. The sorted stack is then popped,
  // largest first, into the queue of results owed.
  task automatic take_value(input logic [31:0] v, input bit is_last, input bit keep);
    logic signed [31:0] held;
    sorted_word_t       w;
    if (src_n < DEPTH) begin
      src_stk[src_n] = v;
      src_n++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!is_last) return;

    // The source stack is never empty here: either this value was kept or it is full.
    srt_n = 0;
    src_n--;
    held = src_stk[src_n];
    while (src_n > 0 || (srt_n > 0 && srt_stk[srt_n-1] > held)) begin
      if (srt_n == 0 || srt_stk[srt_n-1] <= held) begin
        srt_stk[srt_n] = held;
        srt_n++;
        src_n--;
        held = src_stk[src_n];
      end else begin
        srt_n--;
        src_stk[src_n] = srt_stk[srt_n];
        src_n++;
      end
    end
    srt_stk[srt_n] = held;
    srt_n++;

    while (srt_n > 0) begin
      srt_n--;
      w.value = srt_stk[srt_n];
      w.last  = (srt_n == 0);
      w.ovf   = ovf_seen;
      if (keep) pending_words.push_back(w);
    end
    src_n = 0;
    ovf_seen = 1'b0;
  endtask

  // Offers one value on the input channel and returns at the clock edge where the
  // transfer happens. Ready is looked at on the falling edge, where it is settled for
  // the coming rising edge, so nothing hinges on event order inside a time step.
  task automatic send_value(input logic [31:0] v, input bit is_last, input bit gaps);
    if (gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic add_row(input logic [31:0] v, input bit is_last, input bit typed,
                         input logic [31:0] exp_value);
    load_row_t r;
    r.value = v;
    r.last = is_last;
    r.typed = typed;
    r.exp_value = exp_value;
    load_rows.push_back(r);
  endtask

  // Draws a value: full-range noise, a narrow band that makes ties likely, or a value
  // near either end of the signed range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 2)
                                           : 32'h8000_0000 + $urandom_range(0, 2);
    endcase
  endfunction

  // Receiver: ready in random stall bursts, in windows with and without stalls, plus
  // one long hold-off on request. The hold-off is counted here, not by the sender.
  initial begin : receiver
    int window;
    bit stalls;
    window = 0;
    stalls = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      window++;
      if (window >= 64) begin
        window = 0;
        stalls = $urandom_range(0, 2) != 0;
      end
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stalls && !calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker. A transfer that will happen at the next rising edge is seen on
  // the falling edge before it, with valid and ready both settled.
  always @(negedge clk) begin
    sorted_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result value=%0d last=%0b ovf=%0b", $realtime,
                   $signed(out_tdata), out_tlast, out_tuser);
      end else begin
        w = pending_words.pop_front();
        if (out_tdata !== w.value || out_tlast !== w.last || out_tuser !== w.ovf) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                     $realtime, $signed(w.value), w.last, w.ovf,
                     $signed(out_tdata), out_tlast, out_tuser);
        end
      end
    end
  end

  initial begin : stimulus
    sorted_word_t w;
    load_row_t    r;
    int           set_len;
    int           set_idx;
    int           rand_sent;
    bit           gaps;

    // Directed table. Single-value sets at the extremes and around zero carry their
    // result in the row; the rest go through the predictor.
    add_row(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF);
    add_row(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000);
    add_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // Ties around the most negative value.
    add_row(32'd5, 1'b0, 1'b0, '0);
    add_row(32'd5, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b0, 1'b0, '0);
    add_row(32'd5, 1'b1, 1'b0, '0);
    // Ascending input: the sort has to shuttle back and forth a lot.
    for (int i = 1; i <= 5; i++) add_row(i, i == 5, 1'b0, '0);
    // Descending input across the whole signed range.
    add_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'd100, 1'b0, 1'b0, '0);
    add_row(32'd0, 1'b0, 1'b0, '0);
    add_row(-32'sd100, 1'b0, 1'b0, '0);
    add_row(32'h8000_0000, 1'b1, 1'b0, '0);
    // Alternating signs with repeats.
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'd1, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'd1, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (load_rows[i]) begin
      r = load_rows[i];
      send_value(r.value, r.last, 1'b1);
      if (r.typed) begin
        take_value(r.value, r.last, 1'b0);
        w.value = r.exp_value;
        w.last  = 1'b1;
        w.ovf   = 1'b0;
        pending_words.push_back(w);
      end else begin
        take_value(r.value, r.last, 1'b1);
      end
    end

    // Random sets. Most are short; one fills the stack exactly and one runs past
    // it, so the final values and the closing value itself are dropped. The long
    // receiver hold-off starts with the first random set, so the following sets
    // pile up behind it and the core has to stall its input.
    hold_req = 1'b1;
    rand_sent = 0;
    set_idx = 0;
    while (rand_sent < 200) begin
      case (set_idx)
        3: set_len = DEPTH;
        9: set_len = DEPTH + 2;
        default: set_len = $urandom_range(0, 3) == 0 ? $urandom_range(6, 16)
                                                     : $urandom_range(1, 5);
      endcase
      gaps = $urandom_range(0, 2) != 0;
      for (int k = 0; k < set_len; k++) begin
        if (rand_sent >= 200 - CALM_TAIL) calm = 1'b1;
        r.value = pick_value();
        r.last = (k == set_len - 1);
        send_value(r.value, r.last, gaps);
        take_value(r.value, r.last, 1'b1);
        rand_sent++;
      end
      set_idx++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ two_stack_sort_core.f @@
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tss_ram.sv
rtl/core/two_stack_sort_core.sv
rtl/core/tss_checker.sv
bench/testbench.sv
